// ===== src/yuvrgb_pkg.sv =====
// Shared types and constants for the YUYV to RGB888 converter.
`default_nettype none

package yuvrgb_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CHR_W  = PIX_W + 1;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned DLT_W  = 10;
  localparam int unsigned CH_W   = DLT_W + 1;
  localparam int unsigned SCL_W  = 2 * PIX_W;

  localparam int unsigned Q14_SHIFT   = 14;
  localparam int unsigned Q14_MASK    = 16383;
  localparam int unsigned CHROMA_OFS  = 128;
  localparam int unsigned SCALE_NUM   = 220;
  localparam int unsigned SCALE_SHIFT = 8;

  localparam logic signed [COEF_W-1:0] V0_CR  = 16'sd22987;
  localparam logic signed [COEF_W-1:0] V0_CGV = -16'sd11698;
  localparam logic signed [COEF_W-1:0] V0_CGU = -16'sd5636;
  localparam logic signed [COEF_W-1:0] V0_CB  = 16'sd29049;
  localparam logic signed [COEF_W-1:0] V1_CR  = 16'sd22458;
  localparam logic signed [COEF_W-1:0] V1_CGV = 16'sd11436;
  localparam logic signed [COEF_W-1:0] V1_CGU = 16'sd5532;
  localparam logic signed [COEF_W-1:0] V1_CB  = 16'sd28384;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;
  localparam logic [APB_AW-1:0] REG_VARIANT = 3'd0;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
    logic             frame_end;
  } yuyv_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
    logic             last_pair;
  } rgb_t;

  typedef struct packed {
    logic [PIX_W-1:0]         y0;
    logic [PIX_W-1:0]         y1;
    logic                     variant;
    logic                     last;
    logic signed [PROD_W-1:0] pr;
    logic signed [PROD_W-1:0] pgv;
    logic signed [PROD_W-1:0] pgu;
    logic signed [PROD_W-1:0] pb;
  } prod_t;

  typedef struct packed {
    logic [PIX_W-1:0]        y0;
    logic [PIX_W-1:0]        y1;
    logic                    variant;
    logic                    last;
    logic signed [DLT_W-1:0] dr;
    logic signed [DLT_W-1:0] dg;
    logic signed [DLT_W-1:0] db;
  } dlt_t;

endpackage

`default_nettype wire

// ===== src/yuyv_to_rgb_converter.sv =====
// Top level: YUYV 4:2:2 pair to two RGB888 pixels, three-stage pipeline.
// A pair passes through three register stages (products, deltas, pixels) in order before it is offered.
// Throughput: one pair per cycle while the output is not stalled; each stage register advances when empty or unstalled.
// A full pipeline stalls the input only while the output register is held.
// Reset clears all stage valid bits and sets variant to 0.
`default_nettype none

module yuyv_to_rgb_converter (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire  [yuvrgb_pkg::APB_AW-1:0]   paddr,
  input  wire  [yuvrgb_pkg::APB_DW-1:0]   pwdata,
  output logic [yuvrgb_pkg::APB_DW-1:0]   prdata,
  output logic                            pready,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  yuvrgb_pkg::yuyv_t               in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output yuvrgb_pkg::rgb_t                out_data_o
);
  import yuvrgb_pkg::*;

  logic  variant_q, variant_d;
  logic  cfg_wr;
  logic  s1_valid, s1_stall, s2_valid, s2_stall;
  prod_t s1_data;
  dlt_t  s2_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_VARIANT);

  always_comb begin
    variant_d = variant_q;
    if (cfg_wr) begin
      variant_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
    end else begin
      variant_q <= variant_d;
    end
  end

  assign prdata = (paddr == REG_VARIANT) ? APB_DW'(variant_q) : '0;

  yuvrgb_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .variant_i   (variant_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (s1_valid),
    .out_stall_i (s1_stall),
    .out_data_o  (s1_data)
  );

  yuvrgb_dlt u_dlt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_stall_o  (s1_stall),
    .in_data_i   (s1_data),
    .out_valid_o (s2_valid),
    .out_stall_i (s2_stall),
    .out_data_o  (s2_data)
  );

  yuvrgb_pix u_pix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_stall_o  (s2_stall),
    .in_data_i   (s2_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid && out_valid_o && out_stall_i))
    else $error("input stalled with a free stage");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !s2_valid) |=> !out_valid_o)
    else $error("output valid without a source transfer");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (variant_q == $past(pwdata[0])))
    else $error("variant register not updated");

  a_mid_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_stall) |=> s2_valid)
    else $error("middle stage lost a transfer");

endmodule

`default_nettype wire

// ===== src/yuvrgb_mul.sv =====
// First stage: chroma offset removal and coefficient products.
`default_nettype none

module yuvrgb_mul (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  variant_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  yuvrgb_pkg::yuyv_t    in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output yuvrgb_pkg::prod_t    out_data_o
);
  import yuvrgb_pkg::*;

  logic                     valid_q;
  logic                     advance;
  prod_t                    data_d, data_q;
  logic signed [CHR_W-1:0]  u, v;
  logic signed [COEF_W-1:0] cr, cgv, cgu, cb;

  assign advance    = !valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_comb begin
    u = $signed({1'b0, in_data_i.chroma_blue}) - $signed(CHR_W'(CHROMA_OFS));
    v = $signed({1'b0, in_data_i.chroma_red}) - $signed(CHR_W'(CHROMA_OFS));
    if (variant_i) begin
      cr  = V1_CR;
      cgv = V1_CGV;
      cgu = V1_CGU;
      cb  = V1_CB;
    end else begin
      cr  = V0_CR;
      cgv = V0_CGV;
      cgu = V0_CGU;
      cb  = V0_CB;
    end
    data_d.y0      = in_data_i.luma_first;
    data_d.y1      = in_data_i.luma_second;
    data_d.variant = variant_i;
    data_d.last    = in_data_i.frame_end;
    data_d.pr      = PROD_W'(cr) * PROD_W'(v);
    data_d.pgv     = PROD_W'(cgv) * PROD_W'(v);
    data_d.pgu     = PROD_W'(cgu) * PROD_W'(u);
    data_d.pb      = PROD_W'(cb) * PROD_W'(u);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== src/yuvrgb_dlt.sv =====
// Second stage: Q14 product scaling to per-channel chroma deltas.
`default_nettype none

module yuvrgb_dlt (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  yuvrgb_pkg::prod_t    in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output yuvrgb_pkg::dlt_t     out_data_o
);
  import yuvrgb_pkg::*;

  logic                    valid_q;
  logic                    advance;
  dlt_t                    data_d, data_q;
  logic signed [SUM_W-1:0] gsum;

  function automatic logic signed [DLT_W-1:0] trunc_q14(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? $signed(PROD_W'(Q14_MASK)) : $signed(PROD_W'(0)));
    return DLT_W'(adj >>> Q14_SHIFT);
  endfunction

  assign advance    = !valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_comb begin
    gsum           = SUM_W'(in_data_i.pgv) + SUM_W'(in_data_i.pgu);
    data_d.y0      = in_data_i.y0;
    data_d.y1      = in_data_i.y1;
    data_d.variant = in_data_i.variant;
    data_d.last    = in_data_i.last;
    if (in_data_i.variant) begin
      data_d.dr = trunc_q14(in_data_i.pr);
      data_d.dg = -trunc_q14(in_data_i.pgv) - trunc_q14(in_data_i.pgu);
      data_d.db = trunc_q14(in_data_i.pb);
    end else begin
      data_d.dr = DLT_W'(in_data_i.pr >>> Q14_SHIFT);
      data_d.dg = DLT_W'(gsum >>> Q14_SHIFT);
      data_d.db = DLT_W'(in_data_i.pb >>> Q14_SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== src/yuvrgb_pix.sv =====
// Third stage: luma plus delta, clamp, optional 220/256 scaling, output register.
`default_nettype none

module yuvrgb_pix (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  yuvrgb_pkg::dlt_t     in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output yuvrgb_pkg::rgb_t     out_data_o
);
  import yuvrgb_pkg::*;

  logic valid_q;
  logic advance;
  rgb_t data_d, data_q;

  function automatic logic [PIX_W-1:0] chan(logic [PIX_W-1:0] y,
                                            logic signed [DLT_W-1:0] d,
                                            logic scale);
    logic signed [CH_W-1:0] s;
    logic [PIX_W-1:0]       c;
    logic [SCL_W-1:0]       p;
    s = $signed({{(CH_W-PIX_W){1'b0}}, y}) + CH_W'(d);
    if (s < 0) begin
      c = '0;
    end else if (s > $signed(CH_W'(255))) begin
      c = '1;
    end else begin
      c = s[PIX_W-1:0];
    end
    p = SCL_W'(c) * SCL_W'(SCALE_NUM);
    return scale ? p[SCALE_SHIFT +: PIX_W] : c;
  endfunction

  assign advance    = !valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  always_comb begin
    data_d.red_first    = chan(in_data_i.y0, in_data_i.dr, in_data_i.variant);
    data_d.green_first  = chan(in_data_i.y0, in_data_i.dg, in_data_i.variant);
    data_d.blue_first   = chan(in_data_i.y0, in_data_i.db, in_data_i.variant);
    data_d.red_second   = chan(in_data_i.y1, in_data_i.dr, in_data_i.variant);
    data_d.green_second = chan(in_data_i.y1, in_data_i.dg, in_data_i.variant);
    data_d.blue_second  = chan(in_data_i.y1, in_data_i.db, in_data_i.variant);
    data_d.last_pair    = in_data_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== tb/yuyv_to_rgb_converter_test.sv =====
// Self-checking testbench for the YUYV pair to RGB888 converter: directed and random pairs.
`timescale 1ns / 100ps

class rgb_pair_scoreboard;
  bit variant;
  int error_count;
  yuvrgb_pkg::rgb_t expected_pixels[$];

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function void set_variant(bit v);
    variant = v;
  endfunction

  function int pending();
    return expected_pixels.size();
  endfunction

  // clamp to 0..255, then apply the 220/256 scaling of the alternate path
  function logic [7:0] shape_channel(int x);
    int c;
    c = (x < 0) ? 0 : ((x > 255) ? 255 : x);
    if (variant) c = (c * 220) >>> 8;
    return c[7:0];
  endfunction

  function yuvrgb_pkg::rgb_t convert_pair(yuvrgb_pkg::yuyv_t p);
    yuvrgb_pkg::rgb_t o;
    int u, v, dr, dg, db;
    u = int'(p.chroma_blue) - 128;
    v = int'(p.chroma_red) - 128;
    if (!variant) begin
      dr = (22987 * v) >>> 14;
      dg = (-5636 * u - 11698 * v) >>> 14;
      db = (29049 * u) >>> 14;
    end else begin
      dr = (22458 * v) / 16384;
      dg = -((11436 * v) / 16384) - ((5532 * u) / 16384);
      db = (28384 * u) / 16384;
    end
    o.red_first    = shape_channel(int'(p.luma_first) + dr);
    o.green_first  = shape_channel(int'(p.luma_first) + dg);
    o.blue_first   = shape_channel(int'(p.luma_first) + db);
    o.red_second   = shape_channel(int'(p.luma_second) + dr);
    o.green_second = shape_channel(int'(p.luma_second) + dg);
    o.blue_second  = shape_channel(int'(p.luma_second) + db);
    o.last_pair    = p.frame_end;
    return o;
  endfunction

  function void note_pair(yuvrgb_pkg::yuyv_t p);
    expected_pixels.push_back(convert_pair(p));
  endfunction

  task check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task check_pixels(yuvrgb_pkg::rgb_t got);
    yuvrgb_pkg::rgb_t want;
    if (expected_pixels.size() == 0) begin
      report("result with no pair pending");
      return;
    end
    want = expected_pixels.pop_front();
    check_field("red_first", got.red_first, want.red_first);
    check_field("green_first", got.green_first, want.green_first);
    check_field("blue_first", got.blue_first, want.blue_first);
    check_field("red_second", got.red_second, want.red_second);
    check_field("green_second", got.green_second, want.green_second);
    check_field("blue_second", got.blue_second, want.blue_second);
    check_field("last_pair", {7'd0, got.last_pair}, {7'd0, want.last_pair});
  endtask
endclass

module yuyv_to_rgb_converter_test;
  import yuvrgb_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 128;
  localparam int NUM_DIRECTED = 12;
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 3'd4;

  localparam logic [32:0] DIRECTED_PAIRS [NUM_DIRECTED] = '{
    {8'd0,   8'd128, 8'd0,   8'd128, 1'b0},
    {8'd255, 8'd128, 8'd255, 8'd128, 1'b1},
    {8'd0,   8'd0,   8'd0,   8'd0,   1'b0},
    {8'd255, 8'd255, 8'd255, 8'd255, 1'b0},
    {8'd255, 8'd0,   8'd255, 8'd0,   1'b1},
    {8'd0,   8'd255, 8'd0,   8'd255, 1'b0},
    {8'd0,   8'd255, 8'd255, 8'd0,   1'b0},
    {8'd255, 8'd0,   8'd0,   8'd255, 1'b1},
    {8'd16,  8'd127, 8'd235, 8'd129, 1'b0},
    {8'd128, 8'd129, 8'd128, 8'd127, 1'b0},
    {8'd235, 8'd240, 8'd16,  8'd16,  1'b1},
    {8'd85,  8'd170, 8'd170, 8'd85,  1'b0}
  };

  localparam logic [7:0] CHROMA_EDGES [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  yuyv_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rgb_t out_data_o;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int quiet_cycles = 0;

  rgb_pair_scoreboard sb = new();

  yuyv_to_rgb_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_pixels(out_data_o);
    out_stall_i <= ($urandom_range(99) < snk_stall_pct);
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_VARIANT) sb.set_variant(data[0]);
  endtask

  task automatic check_variant_readback();
    logic [APB_DW-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_VARIANT;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {31'd0, sb.variant})
      sb.report($sformatf("variant readback got %0h want %0d", got, sb.variant));
  endtask

  task automatic send_pair(input yuyv_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pair(p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_variant(input bit v);
    drain();
    apb_write(REG_VARIANT, ($urandom() & ~APB_DW'(1)) | APB_DW'(v));
    check_variant_readback();
  endtask

  function automatic yuyv_t random_pair();
    yuyv_t p;
    p.luma_first = 8'($urandom());
    p.luma_second = 8'($urandom());
    p.chroma_blue = ($urandom_range(3) == 0) ? CHROMA_EDGES[$urandom_range(6)]
                                             : 8'($urandom());
    p.chroma_red = ($urandom_range(3) == 0) ? CHROMA_EDGES[$urandom_range(6)]
                                            : 8'($urandom());
    p.frame_end = ($urandom_range(15) == 0);
    return p;
  endfunction

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes past the register list must leave variant alone
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    check_variant_readback();
    for (int i = 0; i < NUM_DIRECTED; i++) send_pair(yuyv_t'(DIRECTED_PAIRS[i]));

    set_variant(1'b1);
    for (int i = 0; i < NUM_DIRECTED; i++) send_pair(yuyv_t'(DIRECTED_PAIRS[i]));

    for (int ph = 0; ph < 8; ph++) begin
      set_variant(ph[0]);
      unique case (ph >> 1)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
        default: begin src_idle_pct = 21; snk_stall_pct = 21; end
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_pair(random_pair());
    end

    drain();
    if (sb.error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
